@@ hdl/zhang_suen_thinning_pass_macros.svh @@
// Assertion helpers shared by the thinning pass RTL.
// Every property is sampled on the rising edge of clk and is off while rst is high.
`ifndef ZHANG_SUEN_THINNING_PASS_MACROS_SVH
`define ZHANG_SUEN_THINNING_PASS_MACROS_SVH

// The condition holds at every edge.
`define ZST_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// The consequence holds in the same cycle as the antecedent.
`define ZST_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequence holds in the cycle after the antecedent.
`define ZST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/zst_pkg.sv @@
package zst_pkg;

  localparam int PIX_W             = 8;
  localparam int CFG_W             = 12;
  localparam int CFG_IDX_W         = 2;
  localparam int WIDTH_FIELD_W     = 11;
  localparam int HEIGHT_FIELD_W    = 12;
  localparam int ROW_W             = 13;
  localparam int MIN_SIZE          = 3;
  localparam int DEFAULT_MAX_WIDTH = 1024;
  localparam int RESET_WIDTH       = 1024;
  localparam int RESET_HEIGHT      = 1024;
  localparam int NEIGHBOR_LIMIT    = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_SUBITERATION = 2'd2
  } cfg_reg_t;

  typedef logic [PIX_W-1:0] pixel_t;

  // One line store entry: the row two above and the row just above.
  typedef struct packed {
    pixel_t upper;
    pixel_t lower;
  } line_pair_t;

  typedef struct packed {
    logic emit;
    logic interior;
    logic last;
  } stage_ctl_t;

  // Window foreground bits are indexed row * 3 + column, column 2 newest.
  function automatic logic center_deletable(logic [8:0] fgb, logic subiter);
    logic [7:0] nb;
    logic [3:0] count;
    logic [3:0] trans;
    logic       n, e, s, w;
    logic       rule_ok;
    // Neighbors in cyclic order N, NE, E, SE, S, SW, W, NW.
    nb = {fgb[0], fgb[3], fgb[6], fgb[7], fgb[8], fgb[5], fgb[2], fgb[1]};
    count = '0;
    trans = '0;
    for (int k = 0; k < 8; k++) begin
      count = count + 4'(nb[k]);
      trans = trans + 4'(!nb[k] && nb[(k + 1) % 8]);
    end
    n = nb[0];
    e = nb[2];
    s = nb[4];
    w = nb[6];
    if (subiter) begin
      rule_ok = !(n && e && w) && !(n && s && w);
    end else begin
      rule_ok = !(n && e && s) && !(e && s && w);
    end
    return fgb[4] && (count >= 4'd2) && (count < 4'(NEIGHBOR_LIMIT)) &&
           (trans == 4'd1) && rule_ok;
  endfunction

endpackage

@@ hdl/zst_line_store.sv @@
module zst_line_store #(
  parameter int DEPTH = zst_pkg::DEFAULT_MAX_WIDTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output zst_pkg::line_pair_t rd_data,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  zst_pkg::line_pair_t wr_data
);
  import zst_pkg::*;

  line_pair_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/zst_window.sv @@
module zst_window (
  input  logic                clk,
  input  logic                rst,
  input  logic                clear,
  input  logic                shift,
  input  logic                frame_end,
  input  zst_pkg::line_pair_t col_rd,
  input  zst_pkg::pixel_t     pix_in,
  input  logic                subiter,
  output zst_pkg::pixel_t     center,
  output logic                deletable
);
  import zst_pkg::*;

  logic [8:0][PIX_W-1:0] win;
  logic [8:0][PIX_W-1:0] win_next;
  logic [8:0]            fgb;

  // The window as it stands once the new column has shifted in; the
  // decision is taken on this view.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_next[k * 3 + 0] = win[k * 3 + 1];
      win_next[k * 3 + 1] = win[k * 3 + 2];
    end
    win_next[2] = col_rd.upper;
    win_next[5] = col_rd.lower;
    win_next[8] = pix_in;
    for (int i = 0; i < 9; i++) begin
      fgb[i] = (win_next[i] != '0);
    end
    center    = win_next[4];
    deletable = center_deletable(fgb, subiter);
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      win <= '0;
    end else if (shift) begin
      if (frame_end) begin
        win <= '0;
      end else begin
        win <= win_next;
      end
    end
  end

endmodule

@@ hdl/zhang_suen_thinning_pass.sv @@
// One Zhang-Suen thinning subiteration over a raster-order 8-bit image: pixels enter
// one word per cycle and each leaves one row plus one pixel later, unchanged or
// cleared to zero when the selected subiteration rule deletes it. After the last
// pixel of a frame send image_width + 1 pad words to drain the window; frame_last
// marks the final result and any_deleted is the running flag the host checks to
// decide whether another pass is needed. Throughput is one pixel per clock when the
// output is not stalled; the two line stores share one memory, read at the column
// counter as a word is taken into the window stage and written back as it leaves
// that stage. Writing any register restarts the frame.
`include "zhang_suen_thinning_pass_macros.svh"

module zhang_suen_thinning_pass #(
  parameter int MAX_WIDTH = zst_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [zst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [zst_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [zst_pkg::PIX_W-1:0]     pixel,
  input  logic                          pad,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [zst_pkg::PIX_W-1:0]     pixel_out,
  output logic                          deleted,
  output logic                          frame_last,
  output logic                          any_deleted
);
  import zst_pkg::*;

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int CW    = (WW > WIDTH_FIELD_W) ? WW : WIDTH_FIELD_W;
  localparam int RST_W = (RESET_WIDTH < MAX_WIDTH) ? RESET_WIDTH : MAX_WIDTH;

  // Configuration, held already clamped to the supported range.
  logic [WW-1:0]             width_eff;
  logic [HEIGHT_FIELD_W-1:0] height_eff;
  logic                      subiter;
  logic [WW-1:0]             width_clamped;
  logic [HEIGHT_FIELD_W-1:0] height_clamped;
  logic [CW-1:0]             width_req;
  logic                      cfg_restart;

  // Input position in the frame.
  logic [AW-1:0]    col_count;
  logic [ROW_W-1:0] row_count;
  logic [AW-1:0]    col_count_next;
  logic [ROW_W-1:0] row_count_next;
  logic [ROW_W-1:0] h_ext;
  logic [WW-1:0]    col_plus;

  logic       in_fire;
  stage_ctl_t in_ctl;
  pixel_t     in_pix;

  logic       s1_valid;
  logic       s1_go;
  stage_ctl_t s1_ctl;
  pixel_t     s1_pix;
  logic [AW-1:0] s1_addr;

  line_pair_t rd_pair;
  line_pair_t wr_pair;
  pixel_t     center;
  logic       deletable;
  logic       del;
  logic       out_load;
  logic       seen;

  always_comb begin
    width_req = CW'(cfg_data[WIDTH_FIELD_W-1:0]);
    if (width_req < CW'(MIN_SIZE)) begin
      width_clamped = WW'(MIN_SIZE);
    end else if (width_req > CW'(MAX_WIDTH)) begin
      width_clamped = WW'(MAX_WIDTH);
    end else begin
      width_clamped = WW'(width_req);
    end
    // The field cannot exceed the largest supported height, so only the low end clamps.
    if (cfg_data[HEIGHT_FIELD_W-1:0] < HEIGHT_FIELD_W'(MIN_SIZE)) begin
      height_clamped = HEIGHT_FIELD_W'(MIN_SIZE);
    end else begin
      height_clamped = cfg_data[HEIGHT_FIELD_W-1:0];
    end
    case (cfg_index)
      REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_SUBITERATION: cfg_restart = cfg_write;
      default: cfg_restart = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff  <= WW'(RST_W);
      height_eff <= HEIGHT_FIELD_W'(RESET_HEIGHT);
      subiter    <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  width_eff  <= width_clamped;
        REG_IMAGE_HEIGHT: height_eff <= height_clamped;
        REG_SUBITERATION: subiter    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Position decode for the word being taken. The result of a word at (r, c)
  // is the pixel one row and one column back, so the first row and a pixel
  // produce nothing and the frame ends on column 0 of the second drain row.
  always_comb begin
    h_ext           = ROW_W'(height_eff);
    col_plus        = WW'(col_count) + WW'(1);
    in_fire         = in_valid && in_ready;
    in_ctl.emit     = !((row_count == '0) || ((row_count == ROW_W'(1)) && (col_count == '0)));
    in_ctl.interior = (col_count >= AW'(2)) && (row_count >= ROW_W'(2)) && (row_count < h_ext);
    in_ctl.last     = (row_count == h_ext + ROW_W'(1)) && (col_count == '0);
    in_pix          = (pad || (row_count >= h_ext)) ? '0 : pixel;
    if (in_ctl.last) begin
      col_count_next = '0;
      row_count_next = '0;
    end else if (col_plus == width_eff) begin
      col_count_next = '0;
      row_count_next = row_count + ROW_W'(1);
    end else begin
      col_count_next = AW'(col_plus);
      row_count_next = row_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_restart) begin
      col_count <= '0;
      row_count <= '0;
    end else if (in_fire) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // Window stage. A word that produces no result still moves through so the
  // window and the line stores stay in step.
  assign s1_go    = s1_valid && (!s1_ctl.emit || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ctl  <= in_ctl;
      s1_pix  <= in_pix;
      s1_addr <= col_count;
    end
  end

  assign wr_pair.upper = rd_pair.lower;
  assign wr_pair.lower = s1_pix;

  zst_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (col_count),
    .rd_data (rd_pair),
    .wr_en   (s1_go),
    .wr_addr (s1_addr),
    .wr_data (wr_pair)
  );

  zst_window u_window (
    .clk       (clk),
    .rst       (rst),
    .clear     (cfg_restart),
    .shift     (s1_go),
    .frame_end (s1_ctl.last),
    .col_rd    (rd_pair),
    .pix_in    (s1_pix),
    .subiter   (subiter),
    .center    (center),
    .deletable (deletable)
  );

  assign del      = s1_ctl.interior && deletable;
  assign out_load = s1_go && s1_ctl.emit;

  always_ff @(posedge clk) begin
    if (rst || cfg_restart) begin
      seen <= 1'b0;
    end else if (out_load) begin
      seen <= s1_ctl.last ? 1'b0 : (seen || del);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pixel_out   <= del ? '0 : center;
      deleted     <= del;
      frame_last  <= s1_ctl.last;
      any_deleted <= seen || del;
    end
  end

  `ZST_ASSERT_ALWAYS(a_col_in_range, WW'(col_count) < width_eff, "column counter past row end")
  `ZST_ASSERT_ALWAYS(a_row_in_range, row_count <= h_ext + ROW_W'(1), "row counter past drain")
  `ZST_ASSERT_NEXT(a_last_restarts, in_fire && in_ctl.last, (row_count == '0) && (col_count == '0), "frame did not restart")
  `ZST_ASSERT_IMPLY(a_deleted_is_zero, out_valid && deleted, pixel_out == '0, "deleted pixel not cleared")

endmodule
